[hdl/thick_line_quad_expander_assert.svh]
// Assertion macros for the thick line quad expander.
`ifndef THICK_LINE_QUAD_EXPANDER_ASSERT_SVH
`define THICK_LINE_QUAD_EXPANDER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TLQE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlqe assertion failed");

// Next-cycle implication.
`define TLQE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tlqe assertion failed");

`endif

[hdl/tlqe_pkg.sv]
// Types, constants and helpers shared by the thick line quad expander.
package tlqe_pkg;

   localparam int COORD_W  = 20;
   localparam int DELTA_W  = COORD_W + 1;
   localparam int WIDTH_W  = 12;
   localparam int COLOR_W  = 8;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int PROD_W   = COORD_W + WIDTH_W;
   localparam int WSCALE   = 7;
   localparam int NUM_W    = PROD_W + WSCALE;
   localparam int FRAC_SH  = 16;
   localparam int NSQ      = 29;
   localparam int RAD_W    = 2 * NSQ;
   localparam int ROOT_W   = NSQ;
   localparam int REM_W    = ROOT_W + 2;
   localparam int Q_W      = 12;
   localparam int NDIV     = Q_W;
   localparam int DREM_W   = NUM_W + 1;
   localparam int NRM_W    = Q_W + 1;
   localparam int Q_DEPTH  = 4;
   localparam int QPTR_W   = $clog2(Q_DEPTH);
   localparam int QCNT_W   = QPTR_W + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic [COLOR_W-1:0]        red;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
      logic [COLOR_W-1:0]        alpha;
   } geom_type;

   // One queued segment: squares of the deltas, scaled normal numerators, signs.
   typedef struct packed {
      geom_type          geom;
      logic [SQ_W-1:0]   sqx;
      logic [SQ_W-1:0]   sqy;
      logic [NUM_W-1:0]  numx;
      logic [NUM_W-1:0]  numy;
      logic              negx;
      logic              negy;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [DELTA_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v[DELTA_W-1] != v[DELTA_W-2]) begin
         r = v[DELTA_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

[hdl/tlqe_front.sv]
// Front end: takes segments, forms deltas, squares and numerators, drops zero-length ones.
module tlqe_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_end_y,
   input  logic [tlqe_pkg::WIDTH_W-1:0]        req_line_width,
   input  logic [tlqe_pkg::COLOR_W-1:0]        req_red,
   input  logic [tlqe_pkg::COLOR_W-1:0]        req_green,
   input  logic [tlqe_pkg::COLOR_W-1:0]        req_blue,
   input  logic [tlqe_pkg::COLOR_W-1:0]        req_alpha,
   input  tlqe_pkg::qstat_type                 qstat,
   output logic                               push,
   output tlqe_pkg::job_type                   job
);
   import tlqe_pkg::*;

   logic                        en;
   logic                        f1_valid_ff;
   geom_type                    f1_geom_ff;
   logic signed [DELTA_W-1:0]   f1_dx_ff;
   logic signed [DELTA_W-1:0]   f1_dy_ff;
   logic [WIDTH_W-1:0]          f1_w_ff;
   logic signed [DELTA_W-1:0]   dx_in;
   logic signed [DELTA_W-1:0]   dy_in;
   logic [COORD_W-1:0]          adx;
   logic [COORD_W-1:0]          ady;
   logic [PROD_W-1:0]           prodx;
   logic [PROD_W-1:0]           prody;
   logic                        keep;
   job_type                     job_in;
   logic                        f2_valid_ff;
   job_type                     f2_job_ff;

   // Moves whenever the last stage is empty or has room in the queue.
   assign en        = !(f2_valid_ff && qstat.full);
   assign req_stall = !en;
   assign push      = f2_valid_ff && !qstat.full;
   assign job       = f2_job_ff;

   assign dx_in = {req_end_x[COORD_W-1], req_end_x} - {req_start_x[COORD_W-1], req_start_x};
   assign dy_in = {req_end_y[COORD_W-1], req_end_y} - {req_start_y[COORD_W-1], req_start_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_geom_ff <= '{x1: req_start_x, y1: req_start_y, x2: req_end_x, y2: req_end_y,
                         red: req_red, green: req_green, blue: req_blue, alpha: req_alpha};
         f1_dx_ff   <= dx_in;
         f1_dy_ff   <= dy_in;
         f1_w_ff    <= req_line_width;
         f2_job_ff  <= job_in;
      end
   end

   always_comb begin
      adx    = f1_dx_ff[DELTA_W-1] ? COORD_W'(-f1_dx_ff) : f1_dx_ff[COORD_W-1:0];
      ady    = f1_dy_ff[DELTA_W-1] ? COORD_W'(-f1_dy_ff) : f1_dy_ff[COORD_W-1:0];
      prodx  = PROD_W'(ady) * PROD_W'(f1_w_ff);
      prody  = PROD_W'(adx) * PROD_W'(f1_w_ff);
      keep   = (f1_dx_ff != '0) || (f1_dy_ff != '0);
      job_in.geom = f1_geom_ff;
      job_in.sqx  = SQ_W'(adx) * SQ_W'(adx);
      job_in.sqy  = SQ_W'(ady) * SQ_W'(ady);
      job_in.numx = {prodx, {WSCALE{1'b0}}};
      job_in.numy = {prody, {WSCALE{1'b0}}};
      // nx has the sign of -dy, ny the sign of dx
      job_in.negx = !f1_dy_ff[DELTA_W-1] && (f1_dy_ff != '0);
      job_in.negy = f1_dx_ff[DELTA_W-1];
   end

endmodule

[hdl/tlqe_queue.sv]
// Short queue between the front and back ends.
module tlqe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tlqe_pkg::job_type   wr_job,
   input  logic                pop,
   output tlqe_pkg::job_type   head,
   output tlqe_pkg::qstat_type qstat
);
   import tlqe_pkg::*;

   job_type            q_ff [Q_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  cnt_ff;

   assign head        = q_ff[rd_ptr_ff];
   assign qstat.full  = (cnt_ff == QCNT_W'(Q_DEPTH));
   assign qstat.empty = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= wr_job;
   end

endmodule

[hdl/tlqe_back.sv]
// Back end: pipelined square root, pipelined divides, corner sums and output register.
module tlqe_back (
   input  logic                                clock,
   input  logic                                reset,
   input  tlqe_pkg::qstat_type                  qstat,
   input  tlqe_pkg::job_type                    head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner0_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner0_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner1_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner1_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner2_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner2_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner3_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner3_y,
   output logic [tlqe_pkg::COLOR_W-1:0]        rsp_out_red,
   output logic [tlqe_pkg::COLOR_W-1:0]        rsp_out_green,
   output logic [tlqe_pkg::COLOR_W-1:0]        rsp_out_blue,
   output logic [tlqe_pkg::COLOR_W-1:0]        rsp_out_alpha
);
   import tlqe_pkg::*;

   typedef struct packed {
      geom_type           geom;
      logic [RAD_W-1:0]   rad;
      logic [ROOT_W-1:0]  root;
      logic [REM_W-1:0]   rem;
      logic [NUM_W-1:0]   numx;
      logic [NUM_W-1:0]   numy;
      logic               negx;
      logic               negy;
   } root_type;

   typedef struct packed {
      geom_type           geom;
      logic [ROOT_W-1:0]  len;
      logic [DREM_W-1:0]  remx;
      logic [DREM_W-1:0]  remy;
      logic [Q_W-1:0]     qx;
      logic [Q_W-1:0]     qy;
      logic               negx;
      logic               negy;
   } div_type;

   logic      en;
   root_type  rt_ff       [0:NSQ];
   logic      rt_valid_ff [0:NSQ];
   div_type   dv_ff       [0:NDIV];
   logic      dv_valid_ff [0:NDIV];
   root_type  rt0_in;
   div_type   dv0_in;
   logic      out_valid_ff;
   logic signed [NRM_W-1:0] nx;
   logic signed [NRM_W-1:0] ny;
   logic signed [COORD_W-1:0] c0x_ff, c0y_ff, c1x_ff, c1y_ff, c2x_ff, c2y_ff, c3x_ff, c3y_ff;
   geom_type  out_geom_ff;

   // Whole back pipeline advances together unless a finished item is held.
   assign en  = !(out_valid_ff && rsp_stall);
   assign pop = en && !qstat.empty;

   always_comb begin
      rt0_in.geom = head.geom;
      rt0_in.rad  = {1'b0, (SQ_W + 1)'(head.sqx) + (SQ_W + 1)'(head.sqy), {FRAC_SH{1'b0}}};
      rt0_in.root = '0;
      rt0_in.rem  = '0;
      rt0_in.numx = head.numx;
      rt0_in.numy = head.numy;
      rt0_in.negx = head.negx;
      rt0_in.negy = head.negy;
   end

   always_ff @(posedge clock) begin
      if (reset) rt_valid_ff[0] <= 1'b0;
      else if (en) rt_valid_ff[0] <= pop;
   end

   always_ff @(posedge clock) begin
      if (en) rt_ff[0] <= rt0_in;
   end

   // One result bit of the root per stage, most significant first.
   for (genvar s = 0; s < NSQ; s++) begin : g_root
      root_type           nxt;
      logic [REM_W+1:0]   cat;
      logic [REM_W+1:0]   trial;
      always_comb begin
         nxt   = rt_ff[s];
         cat   = {rt_ff[s].rem, rt_ff[s].rad[2*(NSQ-1-s)+1 -: 2]};
         trial = {2'b00, rt_ff[s].root, 2'b01};
         if (cat >= trial) begin
            nxt.rem  = REM_W'(cat - trial);
            nxt.root = {rt_ff[s].root[ROOT_W-2:0], 1'b1};
         end else begin
            nxt.rem  = REM_W'(cat);
            nxt.root = {rt_ff[s].root[ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) rt_valid_ff[s+1] <= 1'b0;
         else if (en) rt_valid_ff[s+1] <= rt_valid_ff[s];
      end
      always_ff @(posedge clock) begin
         if (en) rt_ff[s+1] <= nxt;
      end
   end

   always_comb begin
      dv0_in.geom = rt_ff[NSQ].geom;
      dv0_in.len  = rt_ff[NSQ].root;
      dv0_in.remx = DREM_W'(rt_ff[NSQ].numx);
      dv0_in.remy = DREM_W'(rt_ff[NSQ].numy);
      dv0_in.qx   = '0;
      dv0_in.qy   = '0;
      dv0_in.negx = rt_ff[NSQ].negx;
      dv0_in.negy = rt_ff[NSQ].negy;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else if (en) dv_valid_ff[0] <= rt_valid_ff[NSQ];
   end

   always_ff @(posedge clock) begin
      if (en) dv_ff[0] <= dv0_in;
   end

   // Restoring divide, one quotient bit per stage for both normal components.
   // The quotient stays at or below half the line width, so Q_W bits cover it.
   for (genvar j = 0; j < NDIV; j++) begin : g_div
      div_type            nxt;
      logic [DREM_W:0]    dvs;
      always_comb begin
         nxt = dv_ff[j];
         dvs = (DREM_W + 1)'(dv_ff[j].len) << (NDIV - 1 - j);
         if ({1'b0, dv_ff[j].remx} >= dvs) begin
            nxt.remx = DREM_W'({1'b0, dv_ff[j].remx} - dvs);
            nxt.qx[NDIV-1-j] = 1'b1;
         end
         if ({1'b0, dv_ff[j].remy} >= dvs) begin
            nxt.remy = DREM_W'({1'b0, dv_ff[j].remy} - dvs);
            nxt.qy[NDIV-1-j] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[j+1] <= 1'b0;
         else if (en) dv_valid_ff[j+1] <= dv_valid_ff[j];
      end
      always_ff @(posedge clock) begin
         if (en) dv_ff[j+1] <= nxt;
      end
   end

   always_comb begin
      nx = dv_ff[NDIV].negx ? -$signed({1'b0, dv_ff[NDIV].qx}) : $signed({1'b0, dv_ff[NDIV].qx});
      ny = dv_ff[NDIV].negy ? -$signed({1'b0, dv_ff[NDIV].qy}) : $signed({1'b0, dv_ff[NDIV].qy});
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (en) out_valid_ff <= dv_valid_ff[NDIV];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_geom_ff <= dv_ff[NDIV].geom;
         c0x_ff <= sat_coord(DELTA_W'(dv_ff[NDIV].geom.x1) + DELTA_W'(nx));
         c0y_ff <= sat_coord(DELTA_W'(dv_ff[NDIV].geom.y1) + DELTA_W'(ny));
         c1x_ff <= sat_coord(DELTA_W'(dv_ff[NDIV].geom.x1) - DELTA_W'(nx));
         c1y_ff <= sat_coord(DELTA_W'(dv_ff[NDIV].geom.y1) - DELTA_W'(ny));
         c2x_ff <= sat_coord(DELTA_W'(dv_ff[NDIV].geom.x2) - DELTA_W'(nx));
         c2y_ff <= sat_coord(DELTA_W'(dv_ff[NDIV].geom.y2) - DELTA_W'(ny));
         c3x_ff <= sat_coord(DELTA_W'(dv_ff[NDIV].geom.x2) + DELTA_W'(nx));
         c3y_ff <= sat_coord(DELTA_W'(dv_ff[NDIV].geom.y2) + DELTA_W'(ny));
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_corner0_x = c0x_ff;
   assign rsp_corner0_y = c0y_ff;
   assign rsp_corner1_x = c1x_ff;
   assign rsp_corner1_y = c1y_ff;
   assign rsp_corner2_x = c2x_ff;
   assign rsp_corner2_y = c2y_ff;
   assign rsp_corner3_x = c3x_ff;
   assign rsp_corner3_y = c3y_ff;
   assign rsp_out_red   = out_geom_ff.red;
   assign rsp_out_green = out_geom_ff.green;
   assign rsp_out_blue  = out_geom_ff.blue;
   assign rsp_out_alpha = out_geom_ff.alpha;

endmodule

[hdl/thick_line_quad_expander.sv]
// Top level of the thick line quad expander.
// Use:
//   req_*  : one segment per item (two Q16.4 endpoints, Q8.4 width, RGBA color).
//   rsp_*  : the four quad corners (saturated Q16.4) and the color, one item per
//            segment; a segment whose endpoints coincide gives no item.
//   Both channels move an item on a clock edge with valid high and stall low.
// Throughput: one segment per clock while rsp_stall stays low.
// Path from input accept to rsp_valid: the 29-stage square root (one root bit
//   per stage) and the 12-stage divide (one quotient bit per stage), plus two
//   front stages, the queue, the root and divide input registers and the
//   output register.
// Reset: synchronous, active high; empties every stage and the queue.
// When the receiver stalls, the whole back pipeline holds and the result stays
//   put; the front keeps taking items until the 4-entry queue is full, then
//   raises req_stall.
module thick_line_quad_expander (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_end_y,
   input  logic [tlqe_pkg::WIDTH_W-1:0]        req_line_width,
   input  logic [tlqe_pkg::COLOR_W-1:0]        req_red,
   input  logic [tlqe_pkg::COLOR_W-1:0]        req_green,
   input  logic [tlqe_pkg::COLOR_W-1:0]        req_blue,
   input  logic [tlqe_pkg::COLOR_W-1:0]        req_alpha,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner0_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner0_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner1_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner1_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner2_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner2_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner3_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner3_y,
   output logic [tlqe_pkg::COLOR_W-1:0]        rsp_out_red,
   output logic [tlqe_pkg::COLOR_W-1:0]        rsp_out_green,
   output logic [tlqe_pkg::COLOR_W-1:0]        rsp_out_blue,
   output logic [tlqe_pkg::COLOR_W-1:0]        rsp_out_alpha
);
   import tlqe_pkg::*;

   `include "thick_line_quad_expander_assert.svh"

   qstat_type qstat;
   logic      q_push;
   logic      q_pop;
   job_type   front_job;
   job_type   q_head;

   tlqe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_line_width (req_line_width),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_alpha      (req_alpha),
      .qstat          (qstat),
      .push           (q_push),
      .job            (front_job)
   );

   tlqe_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (front_job),
      .pop    (q_pop),
      .head   (q_head),
      .qstat  (qstat)
   );

   tlqe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .qstat         (qstat),
      .head          (q_head),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_corner0_x (rsp_corner0_x),
      .rsp_corner0_y (rsp_corner0_y),
      .rsp_corner1_x (rsp_corner1_x),
      .rsp_corner1_y (rsp_corner1_y),
      .rsp_corner2_x (rsp_corner2_x),
      .rsp_corner2_y (rsp_corner2_y),
      .rsp_corner3_x (rsp_corner3_x),
      .rsp_corner3_y (rsp_corner3_y),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha)
   );

   `TLQE_ASSERT_NOW(a_no_overflow, q_push, !qstat.full)
   `TLQE_ASSERT_NOW(a_no_underflow, q_pop, !qstat.empty)
   `TLQE_ASSERT_NOW(a_stall_needs_full, req_stall, qstat.full)
   `TLQE_ASSERT_NEXT(a_pop_fills, q_pop && qstat.full, !qstat.full)

endmodule

[tb/thick_line_quad_expander_tb.sv]
// Self-checking testbench for the thick line quad expander.
`timescale 1ns / 1ps
module thick_line_quad_expander_tb;
   import tlqe_pkg::*;

   localparam int LATENCY   = 46;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 1850;

   typedef struct {
      logic signed [COORD_W-1:0] sx, sy, ex, ey;
      logic [WIDTH_W-1:0]        w;
      logic [COLOR_W-1:0]        r, g, b, a;
   } segment_type;

   typedef struct {
      logic signed [COORD_W-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
      logic [COLOR_W-1:0]        r, g, b, a;
   } quad_type;

   typedef struct {
      segment_type seg;
      bit          fixed;   // expected quad typed in below
      bit          none;    // no quad expected
      quad_type    q;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic [WIDTH_W-1:0] req_line_width = '0;
   logic [COLOR_W-1:0] req_red = '0, req_green = '0, req_blue = '0, req_alpha = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_corner0_x, rsp_corner0_y, rsp_corner1_x, rsp_corner1_y;
   logic signed [COORD_W-1:0] rsp_corner2_x, rsp_corner2_y, rsp_corner3_x, rsp_corner3_y;
   logic [COLOR_W-1:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;

   quad_type    quads_due[$];
   int          errors = 0;
   int          send_idle = 0, recv_idle = 0;
   int          wdog = 0;
   bit          timed_out = 0;

   always #1 clock = ~clock;

   thick_line_quad_expander i_dut (.*);

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp20(input longint v);
      if (v > 524287) return 20'sh7FFFF;
      if (v < -524288) return 20'sh80000;
      return v[COORD_W-1:0];
   endfunction

   // Returns 0 for a zero-length segment.
   function automatic bit expand_quad(input segment_type s, output quad_type q);
      longint x1 = s.sx, y1 = s.sy, x2 = s.ex, y2 = s.ey;
      longint wd = longint'(s.w);
      longint dx, dy, nx, ny;
      longint unsigned sq, len;
      dx = x2 - x1;
      dy = y2 - y1;
      sq = longint'(dx * dx) + longint'(dy * dy);
      q = '{default: '0};
      if (sq == 0) return 0;
      len = int_sqrt(sq << 16);
      if (len == 0) return 0;
      nx = (-dy * wd * 128) / longint'(len);
      ny = (dx * wd * 128) / longint'(len);
      q.c0x = clamp20(x1 + nx); q.c0y = clamp20(y1 + ny);
      q.c1x = clamp20(x1 - nx); q.c1y = clamp20(y1 - ny);
      q.c2x = clamp20(x2 - nx); q.c2y = clamp20(y2 - ny);
      q.c3x = clamp20(x2 + nx); q.c3y = clamp20(y2 + ny);
      q.r = s.r; q.g = s.g; q.b = s.b; q.a = s.a;
      return 1;
   endfunction

   function automatic segment_type seg(input int sx, sy, ex, ey, w, r, g, b, a);
      segment_type s;
      s.sx = COORD_W'(sx); s.sy = COORD_W'(sy); s.ex = COORD_W'(ex); s.ey = COORD_W'(ey);
      s.w = WIDTH_W'(w);
      s.r = COLOR_W'(r); s.g = COLOR_W'(g); s.b = COLOR_W'(b); s.a = COLOR_W'(a);
      return s;
   endfunction

   function automatic quad_type quad(input int c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y,
                                     r, g, b, a);
      quad_type q;
      q.c0x = COORD_W'(c0x); q.c0y = COORD_W'(c0y);
      q.c1x = COORD_W'(c1x); q.c1y = COORD_W'(c1y);
      q.c2x = COORD_W'(c2x); q.c2y = COORD_W'(c2y);
      q.c3x = COORD_W'(c3x); q.c3y = COORD_W'(c3y);
      q.r = COLOR_W'(r); q.g = COLOR_W'(g); q.b = COLOR_W'(b); q.a = COLOR_W'(a);
      return q;
   endfunction

   task automatic check_field(input string name, input longint exp_v, act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // Result side: check, stall at random, watchdog.
   always @(posedge clock) begin
      quad_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (quads_due.size() == 0) begin
               $error("quad received with none expected");
               errors++;
            end else begin
               e = quads_due.pop_front();
               check_field("corner0_x", longint'(e.c0x), longint'(rsp_corner0_x));
               check_field("corner0_y", longint'(e.c0y), longint'(rsp_corner0_y));
               check_field("corner1_x", longint'(e.c1x), longint'(rsp_corner1_x));
               check_field("corner1_y", longint'(e.c1y), longint'(rsp_corner1_y));
               check_field("corner2_x", longint'(e.c2x), longint'(rsp_corner2_x));
               check_field("corner2_y", longint'(e.c2y), longint'(rsp_corner2_y));
               check_field("corner3_x", longint'(e.c3x), longint'(rsp_corner3_x));
               check_field("corner3_y", longint'(e.c3y), longint'(rsp_corner3_y));
               check_field("out_red", longint'(e.r), longint'(rsp_out_red));
               check_field("out_green", longint'(e.g), longint'(rsp_out_green));
               check_field("out_blue", longint'(e.b), longint'(rsp_out_blue));
               check_field("out_alpha", longint'(e.a), longint'(rsp_out_alpha));
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) wdog <= 0;
         else wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) timed_out <= 1;
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Holds one segment on the port until accepted; random gaps before it.
   task automatic send_segment(input vector_type v);
      quad_type q;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_x <= v.seg.sx; req_start_y <= v.seg.sy;
      req_end_x <= v.seg.ex; req_end_y <= v.seg.ey;
      req_line_width <= v.seg.w;
      req_red <= v.seg.r; req_green <= v.seg.g; req_blue <= v.seg.b; req_alpha <= v.seg.a;
      do @(posedge clock); while (req_stall);
      // accepted at this edge: record the expectation
      if (v.fixed) begin
         if (!v.none) quads_due.insert(quads_due.size(), v.q);
      end else if (expand_quad(v.seg, q)) begin
         quads_due.insert(quads_due.size(), q);
      end
   endtask

   function automatic int rand_coord();
      case ($urandom_range(3))
         0: return int'($urandom_range(1048575)) - 524288;
         1: return int'($urandom_range(2000)) - 1000;
         2: return $urandom_range(1) ? 524287 - int'($urandom_range(300))
                                     : -524288 + int'($urandom_range(300));
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   function automatic segment_type rand_segment();
      segment_type s;
      s.sx = COORD_W'(rand_coord()); s.sy = COORD_W'(rand_coord());
      case ($urandom_range(9))
         0: begin s.ex = s.sx; s.ey = s.sy; end          // zero length
         1: begin
            s.ex = COORD_W'(int'(s.sx) + int'($urandom_range(4)) - 2);
            s.ey = COORD_W'(int'(s.sy) + int'($urandom_range(4)) - 2);
         end
         2: begin s.ex = s.sx; s.ey = COORD_W'(rand_coord()); end  // vertical
         3: begin s.ex = COORD_W'(rand_coord()); s.ey = s.sy; end  // horizontal
         default: begin s.ex = COORD_W'(rand_coord()); s.ey = COORD_W'(rand_coord()); end
      endcase
      case ($urandom_range(4))
         0: s.w = '0;
         1: s.w = '1;
         default: s.w = WIDTH_W'($urandom_range(4095));
      endcase
      s.r = COLOR_W'($urandom_range(255)); s.g = COLOR_W'($urandom_range(255));
      s.b = COLOR_W'($urandom_range(255)); s.a = COLOR_W'($urandom_range(255));
      return s;
   endfunction

   initial begin
      vector_type v;
      vector_type table_rows[$];
      int phase_len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      v = '{default: '0};
      v.seg = seg(100, 200, 100, 200, 64, 1, 2, 3, 4); v.fixed = 1; v.none = 1;
      table_rows.insert(table_rows.size(), v);
      v.seg = seg(-524288, -524288, -524288, -524288, 4095, 255, 255, 255, 255);
      table_rows.insert(table_rows.size(), v);
      // zero width: corners on the endpoints
      v = '{default: '0}; v.fixed = 1;
      v.seg = seg(0, 0, 160, 0, 0, 255, 0, 170, 85);
      v.q = quad(0, 0, 0, 0, 160, 0, 160, 0, 255, 0, 170, 85);
      table_rows.insert(table_rows.size(), v);
      // horizontal, width 2 px: normal is one pixel (16) in y
      v.seg = seg(0, 0, 160, 0, 32, 9, 8, 7, 6);
      v.q = quad(0, 16, 0, -16, 160, -16, 160, 16, 9, 8, 7, 6);
      table_rows.insert(table_rows.size(), v);
      // vertical, width 2 px: nx = -dy*w*128/len = -16
      v.seg = seg(0, 0, 0, 160, 32, 0, 0, 0, 0);
      v.q = quad(-16, 0, 16, 0, 16, 160, -16, 160, 0, 0, 0, 0);
      table_rows.insert(table_rows.size(), v);
      // saturation at the top of the range, nx = 2047
      v.seg = seg(524287, 524287, 524287, 0, 4095, 1, 1, 1, 1);
      v.q = quad(524287, 524287, 522240, 524287, 522240, 0, 524287, 0, 1, 1, 1, 1);
      table_rows.insert(table_rows.size(), v);
      v = '{default: '0};
      v.seg = seg(-524288, -524288, 524287, 524287, 4095, 255, 255, 255, 255);
      table_rows.insert(table_rows.size(), v);
      v.seg = seg(524287, -524288, -524288, 524287, 4095, 128, 64, 32, 16);
      table_rows.insert(table_rows.size(), v);
      v.seg = seg(-524288, 0, -524288, 524287, 4095, 0, 0, 0, 0);
      table_rows.insert(table_rows.size(), v);
      v.seg = seg(0, 0, 1, 0, 4095, 1, 2, 4, 8);
      table_rows.insert(table_rows.size(), v);
      v.seg = seg(0, 0, 1, 1, 1, 16, 32, 64, 128);
      table_rows.insert(table_rows.size(), v);
      v.seg = seg(-1, -1, 0, 0, 2048, 170, 85, 170, 85);
      table_rows.insert(table_rows.size(), v);
      v.seg = seg(349525, -349526, -1000, 7, 1365, 85, 170, 85, 170);
      table_rows.insert(table_rows.size(), v);
      v.seg = seg(-524288, 524287, 524287, -524288, 2730, 254, 253, 251, 247);
      table_rows.insert(table_rows.size(), v);
      foreach (table_rows[i]) send_segment(table_rows[i]);

      // three idling phases, with a drain pause between them
      phase_len = N_RANDOM / 3;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 19 : (ph == 1) ? 46 : 0;
         recv_idle = (ph == 0) ? 46 : (ph == 1) ? 19 : 0;
         for (int n = 0; n < phase_len; n++) begin
            v = '{default: '0};
            v.seg = rand_segment();
            send_segment(v);
         end
         req_valid <= 1'b0;
         while (quads_due.size() != 0 && !timed_out) @(posedge clock);
      end
      req_valid <= 1'b0;
      recv_idle = 0;
      while (quads_due.size() != 0 && !timed_out) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (!timed_out && errors == 0 && quads_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         if (quads_due.size() != 0) $error("%0d quads never arrived", quads_due.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      wait (timed_out);
      $error("no handshake for %0d cycles", WDOG_MAX);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/tlqe_pkg.sv
hdl/tlqe_front.sv
hdl/tlqe_queue.sv
hdl/tlqe_back.sv
hdl/thick_line_quad_expander.sv
tb/thick_line_quad_expander_tb.sv
